>>> hdl/stepper_command_sequencer_top_defines.svh
// Assertion macros for the stepper command sequencer.
// Included by stepper_command_sequencer_top.sv; no other dependencies.
`ifndef STEPPER_COMMAND_SEQUENCER_TOP_DEFINES_SVH
`define STEPPER_COMMAND_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCS_ASSERT_NOW(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCS_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/scs_pkg.sv
// Shared types, constants and the coil pattern table for the stepper command sequencer.
// No dependencies.
package scs_pkg;

    localparam int STEPS_W = 20;
    localparam int DEG_W   = 17;
    localparam int HOLD_W  = 4;
    localparam int COIL_W  = 4;

    localparam logic [HOLD_W-1:0] HOLD_MIN = 4'd3;
    localparam logic [HOLD_W-1:0] HOLD_MAX = 4'd10;

    // Steps for a move are floor(mag * 4096 / 360) = floor(mag * 512 / 45).
    // MOVE_MULT is ceil(2^32 / 45); the factor 512 folds into the shift.
    localparam int MOVE_MULT_W = 27;
    localparam int MOVE_PROD_W = DEG_W + MOVE_MULT_W;
    localparam logic [MOVE_MULT_W-1:0] MOVE_MULT = 27'd95443718;
    localparam int MOVE_SHIFT = 23;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_ON    = 3'd1,
        CMD_OFF   = 3'd2,
        CMD_RUN   = 3'd3,
        CMD_STOP  = 3'd4,
        CMD_CW    = 3'd5,
        CMD_CCW   = 3'd6,
        CMD_MOVE  = 3'd7
    } cmd_t;

    function automatic logic [COIL_W-1:0] coil_pattern(input logic cw, input logic [1:0] idx);
        logic [COIL_W-1:0] pat;
        case (idx)
            2'd0:    pat = cw ? 4'h3 : 4'h9;
            2'd1:    pat = cw ? 4'h6 : 4'hC;
            2'd2:    pat = cw ? 4'hC : 4'h6;
            default: pat = cw ? 4'h9 : 4'h3;
        endcase
        return pat;
    endfunction

endpackage

>>> hdl/stepper_command_sequencer_top.sv
// Top level of the stepper command sequencer: command decode, step sequencing and result register.
// Depends on scs_pkg and stepper_command_sequencer_top_defines.svh.
//
//   channel  | signals                              | direction
//   ---------+--------------------------------------+----------
//   input    | in_valid, in_ready, cmd, degrees     | in
//   result   | out_valid, out_ready, coils, motor_on, moving, steps_left | out
//   config   | cfg_wr_en, cfg_wr_data               | in
//
// Each word is processed in the cycle it is accepted; its result is in the output register
// in the next cycle, so one word per cycle is sustained while out_ready stays high.
// The input is ready whenever the output register is empty or is being emptied.
// A stalled result holds its value while the sequencer state waits for the next word.
// Reset clears all control state, selects clockwise and sets the hold time to three milliseconds.
`include "stepper_command_sequencer_top_defines.svh"

module stepper_command_sequencer_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        cmd,
    input  logic signed [scs_pkg::DEG_W-1:0]  degrees,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [scs_pkg::COIL_W-1:0]        coils,
    output logic                              motor_on,
    output logic                              moving,
    output logic [scs_pkg::STEPS_W-1:0]       steps_left,
    input  logic                              cfg_wr_en,
    input  logic [scs_pkg::HOLD_W-1:0]        cfg_wr_data
);

    logic [scs_pkg::HOLD_W-1:0]  hold_reg;
    logic                        enabled_reg, enabled_next;
    logic                        running_reg, running_next;
    logic                        continuous_reg, continuous_next;
    logic                        dir_cw_reg, dir_cw_next;
    logic [scs_pkg::STEPS_W-1:0] steps_reg, steps_next;
    logic                        active_reg, active_next;
    logic                        cyc_cw_reg, cyc_cw_next;
    logic [1:0]                  phase_reg, phase_next;
    logic [scs_pkg::HOLD_W-1:0]  timer_reg, timer_next;
    logic [scs_pkg::COIL_W-1:0]  coil_reg, coil_next;

    logic                        out_valid_reg;
    logic [scs_pkg::COIL_W-1:0]  out_coils_reg;
    logic                        out_on_reg;
    logic                        out_moving_reg;
    logic [scs_pkg::STEPS_W-1:0] out_steps_reg;

    logic                        accept;
    logic [scs_pkg::DEG_W-1:0]   deg_bits;
    logic [scs_pkg::DEG_W-1:0]   mag;
    logic [scs_pkg::MOVE_PROD_W-1:0] move_prod;
    logic [scs_pkg::STEPS_W-1:0] move_steps;
    logic [scs_pkg::HOLD_W-1:0]  timer_inc;
    logic                        want_cont;
    logic                        want_count;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // The magnitude of the most negative angle still fits in the field width.
    assign deg_bits   = degrees;
    assign mag        = deg_bits[scs_pkg::DEG_W-1] ? (~deg_bits + 17'd1) : deg_bits;
    assign move_prod  = scs_pkg::MOVE_PROD_W'(mag) * scs_pkg::MOVE_PROD_W'(scs_pkg::MOVE_MULT);
    // The largest move gives 745654 steps, so the count never exceeds its width.
    assign move_steps = move_prod[scs_pkg::MOVE_SHIFT +: scs_pkg::STEPS_W];
    assign timer_inc  = timer_reg + 4'd1;

    always_comb
    begin
        enabled_next    = enabled_reg;
        running_next    = running_reg;
        continuous_next = continuous_reg;
        dir_cw_next     = dir_cw_reg;
        steps_next      = steps_reg;
        active_next     = active_reg;
        cyc_cw_next     = cyc_cw_reg;
        phase_next      = phase_reg;
        timer_next      = timer_reg;
        coil_next       = coil_reg;

        unique case (scs_pkg::cmd_t'(cmd))
            scs_pkg::CMD_TICK:
            begin
                if (active_reg)
                begin
                    timer_next = timer_inc;
                    if (timer_inc >= hold_reg)
                    begin
                        timer_next = '0;
                        if (phase_reg == 2'd3)
                        begin
                            active_next = 1'b0;
                        end
                        else
                        begin
                            phase_next = phase_reg + 2'd1;
                            coil_next  = scs_pkg::coil_pattern(cyc_cw_reg, phase_reg + 2'd1);
                        end
                    end
                end
            end
            scs_pkg::CMD_ON:
            begin
                enabled_next = 1'b1;
            end
            scs_pkg::CMD_OFF:
            begin
                enabled_next    = 1'b0;
                running_next    = 1'b0;
                continuous_next = 1'b0;
            end
            scs_pkg::CMD_RUN:
            begin
                if (enabled_reg)
                begin
                    running_next    = 1'b1;
                    continuous_next = 1'b1;
                end
            end
            scs_pkg::CMD_STOP:
            begin
                running_next    = 1'b0;
                continuous_next = 1'b0;
            end
            scs_pkg::CMD_CW:
            begin
                dir_cw_next = 1'b1;
            end
            scs_pkg::CMD_CCW:
            begin
                dir_cw_next = 1'b0;
            end
            scs_pkg::CMD_MOVE:
            begin
                if (enabled_reg)
                begin
                    dir_cw_next     = !deg_bits[scs_pkg::DEG_W-1];
                    steps_next      = move_steps;
                    running_next    = 1'b1;
                    continuous_next = 1'b0;
                end
            end
        endcase

        want_cont  = enabled_next && running_next && continuous_next;
        want_count = enabled_next && (steps_next != '0);

        // A new step starts in the same word in which the previous one ends.
        if (!active_next && (want_cont || want_count))
        begin
            active_next = 1'b1;
            cyc_cw_next = dir_cw_next;
            phase_next  = 2'd0;
            timer_next  = '0;
            coil_next   = scs_pkg::coil_pattern(dir_cw_next, 2'd0);
            if (want_count)
            begin
                if (steps_next == 20'd1)
                begin
                    running_next = 1'b0;
                end
                steps_next = steps_next - 20'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg       <= scs_pkg::HOLD_MIN;
            enabled_reg    <= 1'b0;
            running_reg    <= 1'b0;
            continuous_reg <= 1'b0;
            dir_cw_reg     <= 1'b1;
            steps_reg      <= '0;
            active_reg     <= 1'b0;
            cyc_cw_reg     <= 1'b1;
            phase_reg      <= 2'd0;
            timer_reg      <= '0;
            coil_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_wr_data < scs_pkg::HOLD_MIN)
                begin
                    hold_reg <= scs_pkg::HOLD_MIN;
                end
                else if (cfg_wr_data > scs_pkg::HOLD_MAX)
                begin
                    hold_reg <= scs_pkg::HOLD_MAX;
                end
                else
                begin
                    hold_reg <= cfg_wr_data;
                end
            end
            if (accept)
            begin
                enabled_reg    <= enabled_next;
                running_reg    <= running_next;
                continuous_reg <= continuous_next;
                dir_cw_reg     <= dir_cw_next;
                steps_reg      <= steps_next;
                active_reg     <= active_next;
                cyc_cw_reg     <= cyc_cw_next;
                phase_reg      <= phase_next;
                timer_reg      <= timer_next;
                coil_reg       <= coil_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_coils_reg  <= coil_next;
            out_on_reg     <= enabled_next;
            out_moving_reg <= running_next;
            out_steps_reg  <= steps_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign coils      = out_coils_reg;
    assign motor_on   = out_on_reg;
    assign moving     = out_moving_reg;
    assign steps_left = out_steps_reg;

    `SCS_ASSERT_NOW(a_step_drives_two_coils, clk, rst_n, active_reg,
        $countones(coil_reg) == 2, "active step without a two-coil pattern")
    `SCS_ASSERT_NOW(a_running_needs_enable, clk, rst_n, running_reg,
        enabled_reg, "running set while motor disabled")
    `SCS_ASSERT_NEXT(a_steps_count_down, clk, rst_n,
        accept && (cmd != scs_pkg::CMD_MOVE),
        (steps_reg == $past(steps_reg)) || (steps_reg == $past(steps_reg) - 20'd1),
        "step count changed by more than one without a move")

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the stepper command sequencer, with a scoreboard class that
// predicts every result word and random gaps and stalls on both channels.
// Depends on scs_pkg and stepper_command_sequencer_top.
import scs_pkg::*;

typedef struct packed {
    logic [COIL_W-1:0]  coils;
    logic               motor_on;
    logic               moving;
    logic [STEPS_W-1:0] steps_left;
} drive_state_t;

class sequencer_scoreboard;
    logic [HOLD_W-1:0]  hold_ms;
    logic               enabled;
    logic               running;
    logic               continuous;
    logic               dir_cw;
    logic [STEPS_W-1:0] steps_to_go;
    logic               step_busy;
    logic               step_cw;
    logic [1:0]         phase;
    logic [HOLD_W-1:0]  phase_ticks;
    logic [COIL_W-1:0]  coil_out;
    drive_state_t       expected_states[$];
    int unsigned        errors;

    function new();
        hold_ms     = HOLD_MIN;
        enabled     = 1'b0;
        running     = 1'b0;
        continuous  = 1'b0;
        dir_cw      = 1'b1;
        steps_to_go = '0;
        step_busy   = 1'b0;
        step_cw     = 1'b1;
        phase       = 2'd0;
        phase_ticks = '0;
        coil_out    = '0;
        errors      = 0;
    endfunction

    function void set_hold(logic [HOLD_W-1:0] value);
        if (value < HOLD_MIN)
            hold_ms = HOLD_MIN;
        else if (value > HOLD_MAX)
            hold_ms = HOLD_MAX;
        else
            hold_ms = value;
    endfunction

    // The counterclockwise order is the clockwise order read backward.
    function logic [COIL_W-1:0] drive_pattern(logic cw, logic [1:0] idx);
        logic [1:0] pos;
        pos = cw ? idx : 2'd3 - idx;
        case (pos)
            2'd0:    return 4'h3;
            2'd1:    return 4'h6;
            2'd2:    return 4'hC;
            default: return 4'h9;
        endcase
    endfunction

    function void take_word(cmd_t c, logic signed [DEG_W-1:0] deg);
        logic [DEG_W-1:0] mag;
        longint unsigned  count;
        logic             want_run;
        logic             want_count;
        drive_state_t     st;
        case (c)
            CMD_TICK:
                if (step_busy)
                begin
                    phase_ticks = phase_ticks + 1'b1;
                    if (phase_ticks >= hold_ms)
                    begin
                        phase_ticks = '0;
                        if (phase == 2'd3)
                            step_busy = 1'b0;
                        else
                        begin
                            phase    = phase + 2'd1;
                            coil_out = drive_pattern(step_cw, phase);
                        end
                    end
                end
            CMD_ON:
                enabled = 1'b1;
            CMD_OFF:
            begin
                enabled    = 1'b0;
                running    = 1'b0;
                continuous = 1'b0;
            end
            CMD_RUN:
                if (enabled)
                begin
                    running    = 1'b1;
                    continuous = 1'b1;
                end
            CMD_STOP:
            begin
                running    = 1'b0;
                continuous = 1'b0;
            end
            CMD_CW:
                dir_cw = 1'b1;
            CMD_CCW:
                dir_cw = 1'b0;
            default:
                if (enabled)
                begin
                    dir_cw = !deg[DEG_W-1];
                    mag = deg[DEG_W-1] ? DEG_W'(-deg) : DEG_W'(deg);
                    count = 64'(mag) * 64'd4096 / 64'd360;
                    steps_to_go = (count > 64'hFFFFF) ? 20'hFFFFF : count[STEPS_W-1:0];
                    running    = 1'b1;
                    continuous = 1'b0;
                end
        endcase

        if (!step_busy)
        begin
            want_run   = enabled && running && continuous;
            want_count = enabled && (steps_to_go != 0);
            if (want_run || want_count)
            begin
                step_busy   = 1'b1;
                step_cw     = dir_cw;
                phase       = 2'd0;
                phase_ticks = '0;
                coil_out    = drive_pattern(step_cw, 2'd0);
                if (want_count)
                begin
                    steps_to_go = steps_to_go - 1'b1;
                    if (steps_to_go == 0)
                        running = 1'b0;
                end
            end
        end

        st.coils      = coil_out;
        st.motor_on   = enabled;
        st.moving     = running;
        st.steps_left = steps_to_go;
        expected_states.push_back(st);
    endfunction

    function void compare_result(drive_state_t got);
        drive_state_t exp;
        if (expected_states.size() == 0)
        begin
            $display("%0t: result word with nothing expected: %h", $time, got);
            errors++;
            return;
        end
        exp = expected_states.pop_front();
        if (got.coils !== exp.coils)
        begin
            $display("%0t: coils expected %h actual %h", $time, exp.coils, got.coils);
            errors++;
        end
        if (got.motor_on !== exp.motor_on)
        begin
            $display("%0t: motor_on expected %b actual %b", $time, exp.motor_on, got.motor_on);
            errors++;
        end
        if (got.moving !== exp.moving)
        begin
            $display("%0t: moving expected %b actual %b", $time, exp.moving, got.moving);
            errors++;
        end
        if (got.steps_left !== exp.steps_left)
        begin
            $display("%0t: steps_left expected %0d actual %0d", $time, exp.steps_left,
                     got.steps_left);
            errors++;
        end
    endfunction
endclass

module testbench;
    logic                     clk;
    logic                     rst_n       = 1'b0;
    logic                     in_valid    = 1'b0;
    logic [2:0]               cmd         = CMD_TICK;
    logic signed [DEG_W-1:0]  degrees     = '0;
    logic                     out_ready   = 1'b0;
    logic                     cfg_wr_en   = 1'b0;
    logic [HOLD_W-1:0]        cfg_wr_data = '0;
    wire                      in_ready;
    wire                      out_valid;
    wire [COIL_W-1:0]         coils;
    wire                      motor_on;
    wire                      moving;
    wire [STEPS_W-1:0]        steps_left;

    bit                       sender_idles = 1'b1;
    bit                       sink_idles   = 1'b1;
    int unsigned              words_sent   = 0;
    sequencer_scoreboard      board        = new();

    stepper_command_sequencer_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .degrees     (degrees),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .coils       (coils),
        .motor_on    (motor_on),
        .moving      (moving),
        .steps_left  (steps_left),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin : result_sink
        int unsigned  stall;
        drive_state_t got;
        forever
        begin
            stall = sink_idles ? $urandom_range(0, 19) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            got.coils      = coils;
            got.motor_on   = motor_on;
            got.moving     = moving;
            got.steps_left = steps_left;
            board.compare_result(got);
        end
    end

    function automatic logic signed [DEG_W-1:0] random_angle();
        int a;
        a = int'($urandom_range(0, 131070)) - 65535;
        return a[DEG_W-1:0];
    endfunction

    // Mostly zero to two degrees, so that counted moves can finish within a sequence.
    function automatic logic signed [DEG_W-1:0] short_angle();
        int a;
        if ($urandom_range(0, 9) == 0)
            a = int'($urandom_range(0, 65535));
        else
            a = int'($urandom_range(0, 2));
        if ($urandom_range(0, 1) != 0)
            a = -a;
        return a[DEG_W-1:0];
    endfunction

    task automatic send_word(input cmd_t c, input logic signed [DEG_W-1:0] deg);
        int unsigned gap;
        gap = sender_idles ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        degrees  <= deg;
        do @(posedge clk); while (!in_ready);
        board.take_word(c, deg);
        words_sent++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (board.expected_states.size() != 0);
        @(posedge clk);
    endtask

    task automatic write_hold(input logic [HOLD_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.set_hold(value);
    endtask

    task automatic run_sequence();
        int unsigned ticks;
        int unsigned k;
        if ($urandom_range(0, 4) != 0)
            send_word(CMD_ON, random_angle());
        case ($urandom_range(0, 3))
            0:       send_word(CMD_CW, random_angle());
            1:       send_word(CMD_CCW, random_angle());
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0)
            send_word(CMD_RUN, random_angle());
        else
            send_word(CMD_MOVE, short_angle());
        ticks = $urandom_range(10, 250);
        for (k = 0; k < ticks; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_word(cmd_t'($urandom_range(3, 6)), random_angle());
            else
                send_word(CMD_TICK, random_angle());
        end
        case ($urandom_range(0, 2))
            0:       send_word(CMD_STOP, random_angle());
            1:       send_word(CMD_OFF, random_angle());
            default: ;
        endcase
    endtask

    initial
    begin : stimulus
        int unsigned next_cfg_at;
        int unsigned cfg_round;
        logic [HOLD_W-1:0] hold_value;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_hold(4'd0);

        send_word(CMD_TICK, 17'sd0);
        send_word(CMD_MOVE, 17'sd90);
        send_word(CMD_RUN, 17'sd0);
        send_word(CMD_ON, 17'sd0);
        send_word(CMD_MOVE, 17'sd0);
        send_word(CMD_STOP, 17'sd0);
        send_word(CMD_CCW, 17'sd0);
        send_word(CMD_MOVE, 17'sd65535);
        repeat (13) send_word(CMD_TICK, 17'sd0);
        send_word(CMD_MOVE, -17'sd65535);
        send_word(CMD_RUN, 17'sd0);
        send_word(CMD_OFF, 17'sd0);
        send_word(CMD_CW, 17'sd0);

        next_cfg_at = 150;
        cfg_round   = 0;
        while (words_sent < 1000)
        begin
            if (words_sent >= next_cfg_at)
            begin
                wait_for_results();
                case (cfg_round)
                    0:       hold_value = 4'd15;
                    1:       hold_value = 4'd10;
                    2:       hold_value = 4'd3;
                    3:       hold_value = 4'd2;
                    default: hold_value = $urandom_range(0, 15);
                endcase
                write_hold(hold_value);
                cfg_round++;
                next_cfg_at += 150;
            end
            sender_idles = ($urandom_range(0, 3) != 0);
            sink_idles   = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 7)
                run_sequence();
            else
                repeat ($urandom_range(5, 30))
                    send_word(cmd_t'($urandom_range(0, 7)), random_angle());
        end

        wait_for_results();
        repeat (5) @(posedge clk);
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
